/* rtl/core/sorted_keyed_record_table_assert.svh */
// Assertion macros used by the top RTL file of the record table.
`ifndef SORTED_KEYED_RECORD_TABLE_ASSERT_SVH
`define SORTED_KEYED_RECORD_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SKRT_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SKRT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SKRT_ASSERT(lbl, clk, rst_n, expr, msg)
`define SKRT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/skrt_pkg.sv */
package skrt_pkg;
	localparam int DEPTH_DEF    = 256;
	localparam int KEY_BITS_DEF = 31;
	localparam int KIND_W       = 16;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 3;
	localparam int CNT_W        = 9;
	localparam int GROUP        = 16;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ANCESTOR = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_PRESENT    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL       = 3'd3;
	localparam logic [STAT_W-1:0] STAT_WALK_LIMIT = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP, OP_CMP, OP_INSERT, OP_DELETE, OP_UPDATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic lt;
		logic hit;
	} cell_stat_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CMP, S_RED1, S_RED2, S_DECIDE, S_ACT, S_OUT
	} fsm_t;
endpackage

/* rtl/core/sorted_keyed_record_table.sv */
// Sorted keyed record table.
// Input channel (in_valid/in_stall) carries one command: insert, update,
// delete, lookup or find ancestor by kind. Output channel (out_valid/
// out_stall) returns exactly one result per command: status, the record
// found or written, and the record count after the command.
// Records live in a row of cells kept in ascending key order; a search
// compares the key in every cell at once and an insert or delete shifts the
// cells behind the insert point by one place, all in the same cycle.
// A result is formed by the compare step and the two stage registered
// readout tree across the cells; a command that changes the table adds an
// action step, and find ancestor repeats compare and readout per visited record.
// One command is worked on at a time; in_stall is high from acceptance
// until the result has been taken, and the block returns to idle after each result.
// The result holds on the outputs while out_stall is high.
// Reset empties the table; the block is ready once reset is released.
module sorted_keyed_record_table
	import skrt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [KEY_BITS-1:0] key,
	input  logic [KEY_BITS-1:0] parent_key,
	input  logic [KIND_W-1:0]   product_kind,
	input  logic [DATA_W-1:0]   record_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [KEY_BITS-1:0] found_key,
	output logic [KEY_BITS-1:0] found_parent,
	output logic [KIND_W-1:0]   found_kind,
	output logic [DATA_W-1:0]   found_data,
	output logic [CNT_W-1:0]    entry_count
);
`include "sorted_keyed_record_table_assert.svh"
	localparam int KB  = KEY_BITS;
	localparam int D   = TABLE_DEPTH;
	localparam int NG  = (D + GROUP - 1) / GROUP;
	localparam int CW  = $clog2(D + 1);
	localparam int SW  = $clog2(D);

	fsm_t state_q, state_d;
	cell_ctl_t ctl;

	logic [CMD_W-1:0]  cmd_q;
	logic [KB-1:0]     key_q, srch_q, parent_q;
	logic [KIND_W-1:0] kind_q;
	logic [DATA_W-1:0] data_q;
	logic [SW-1:0]     steps_q;
	logic [CW-1:0]     count_q;

	logic [STAT_W-1:0] status_q;
	logic [KB-1:0]     fkey_q, fparent_q;
	logic [KIND_W-1:0] fkind_q;
	logic [DATA_W-1:0] fdata_q;

	logic [KB-1:0]     c_key    [D];
	logic [KB-1:0]     c_parent [D];
	logic [KIND_W-1:0] c_kind   [D];
	logic [DATA_W-1:0] c_data   [D];
	cell_stat_t        c_stat   [D];

	// row of cells
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic              p_lt, p_valid, n_valid;
		logic [KB-1:0]     p_key, p_parent, n_key, n_parent;
		logic [KIND_W-1:0] p_kind, n_kind;
		logic [DATA_W-1:0] p_data, n_data;
		if (i == 0) begin : g_first
			assign p_lt = 1'b1; assign p_valid = 1'b0;
			assign p_key = c_key[i]; assign p_parent = c_parent[i];
			assign p_kind = c_kind[i]; assign p_data = c_data[i];
		end else begin : g_mid
			assign p_lt = c_stat[i-1].lt; assign p_valid = c_stat[i-1].valid;
			assign p_key = c_key[i-1]; assign p_parent = c_parent[i-1];
			assign p_kind = c_kind[i-1]; assign p_data = c_data[i-1];
		end
		if (i == D - 1) begin : g_last
			assign n_valid = 1'b0;
			assign n_key = c_key[i]; assign n_parent = c_parent[i];
			assign n_kind = c_kind[i]; assign n_data = c_data[i];
		end else begin : g_body
			assign n_valid = c_stat[i+1].valid;
			assign n_key = c_key[i+1]; assign n_parent = c_parent[i+1];
			assign n_kind = c_kind[i+1]; assign n_data = c_data[i+1];
		end
		skrt_cell #(.KB(KB)) u_cell (
			.clk, .arst_n, .ctl,
			.in_key(srch_q), .in_parent(parent_q), .in_kind(kind_q), .in_data(data_q),
			.prev_lt(p_lt), .prev_valid(p_valid), .prev_key(p_key),
			.prev_parent(p_parent), .prev_kind(p_kind), .prev_data(p_data),
			.next_valid(n_valid), .next_key(n_key), .next_parent(n_parent),
			.next_kind(n_kind), .next_data(n_data),
			.key_q(c_key[i]), .parent_q(c_parent[i]), .kind_q(c_kind[i]),
			.data_q(c_data[i]), .stat(c_stat[i])
		);
	end

	// readout tree, first stage: OR the hit record within each group
	logic              g_hit_s1    [NG];
	logic [KB-1:0]     g_key_s1    [NG];
	logic [KB-1:0]     g_parent_s1 [NG];
	logic [KIND_W-1:0] g_kind_s1   [NG];
	logic [DATA_W-1:0] g_data_s1   [NG];

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic              m_hit    [GROUP];
		logic [KB-1:0]     m_key    [GROUP];
		logic [KB-1:0]     m_parent [GROUP];
		logic [KIND_W-1:0] m_kind   [GROUP];
		logic [DATA_W-1:0] m_data   [GROUP];
		logic              o_hit;
		logic [KB-1:0]     o_key, o_parent;
		logic [KIND_W-1:0] o_kind;
		logic [DATA_W-1:0] o_data;
		for (genvar l = 0; l < GROUP; l++) begin : g_lane
			if (g * GROUP + l < D) begin : g_on
				assign m_hit[l]    = c_stat[g*GROUP+l].hit;
				assign m_key[l]    = m_hit[l] ? c_key[g*GROUP+l] : '0;
				assign m_parent[l] = m_hit[l] ? c_parent[g*GROUP+l] : '0;
				assign m_kind[l]   = m_hit[l] ? c_kind[g*GROUP+l] : '0;
				assign m_data[l]   = m_hit[l] ? c_data[g*GROUP+l] : '0;
			end else begin : g_off
				assign m_hit[l] = 1'b0; assign m_key[l] = '0; assign m_parent[l] = '0;
				assign m_kind[l] = '0; assign m_data[l] = '0;
			end
		end
		always_comb begin
			o_hit = 1'b0; o_key = '0; o_parent = '0; o_kind = '0; o_data = '0;
			for (int l = 0; l < GROUP; l++) begin
				o_hit    = o_hit | m_hit[l];
				o_key    = o_key | m_key[l];
				o_parent = o_parent | m_parent[l];
				o_kind   = o_kind | m_kind[l];
				o_data   = o_data | m_data[l];
			end
		end
		always_ff @(posedge clk) begin
			g_hit_s1[g]    <= o_hit;
			g_key_s1[g]    <= o_key;
			g_parent_s1[g] <= o_parent;
			g_kind_s1[g]   <= o_kind;
			g_data_s1[g]   <= o_data;
		end
	end

	// readout tree, second stage: OR across groups
	logic              hit_s2;
	logic [KB-1:0]     fk_s2, fp_s2;
	logic [KIND_W-1:0] fn_s2;
	logic [DATA_W-1:0] fd_s2;
	logic              t_hit;
	logic [KB-1:0]     t_key, t_parent;
	logic [KIND_W-1:0] t_kind;
	logic [DATA_W-1:0] t_data;

	always_comb begin
		t_hit = 1'b0; t_key = '0; t_parent = '0; t_kind = '0; t_data = '0;
		for (int g = 0; g < NG; g++) begin
			t_hit    = t_hit | g_hit_s1[g];
			t_key    = t_key | g_key_s1[g];
			t_parent = t_parent | g_parent_s1[g];
			t_kind   = t_kind | g_kind_s1[g];
			t_data   = t_data | g_data_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= t_hit;
		fk_s2  <= t_key;
		fp_s2  <= t_parent;
		fn_s2  <= t_kind;
		fd_s2  <= t_data;
	end

	// decision terms
	logic full, walk_match, walk_end, walk_on;
	assign full       = (count_q == CW'(D));
	assign walk_match = hit_s2 && (fn_s2 == kind_q);
	assign walk_end   = (steps_q == SW'(D - 1));
	assign walk_on    = (cmd_q == CMD_ANCESTOR) && hit_s2 && !walk_match && !walk_end;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state and cell command
	always_comb begin
		state_d = state_q;
		ctl.op  = OP_NOP;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CMP;
			S_CMP: begin
				ctl.op  = OP_CMP;
				state_d = S_RED1;
			end
			S_RED1:  state_d = S_RED2;
			S_RED2:  state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_OUT;
				case (cmd_q)
					CMD_INSERT:   if (!hit_s2 && !full) state_d = S_ACT;
					CMD_UPDATE, CMD_DELETE: if (hit_s2) state_d = S_ACT;
					CMD_ANCESTOR: if (walk_on) state_d = S_CMP;
					default: ;
				endcase
			end
			S_ACT: begin
				case (cmd_q)
					CMD_INSERT: ctl.op = OP_INSERT;
					CMD_DELETE: ctl.op = OP_DELETE;
					default:    ctl.op = OP_UPDATE;
				endcase
				state_d = S_OUT;
			end
			S_OUT:   if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_ACT) begin
			if (cmd_q == CMD_INSERT)      count_q <= count_q + CW'(1);
			else if (cmd_q == CMD_DELETE) count_q <= count_q - CW'(1);
		end
	end

	// result of the command, formed from the readout
	logic [STAT_W-1:0] r_status;
	logic [KB-1:0]     r_key, r_parent;
	logic [KIND_W-1:0] r_kind;
	logic [DATA_W-1:0] r_data;

	always_comb begin
		r_status = STAT_NOT_FOUND;
		r_key    = '0;
		r_parent = '0;
		r_kind   = '0;
		r_data   = '0;
		case (cmd_q)
			CMD_INSERT: begin
				if (hit_s2) begin
					r_status = STAT_PRESENT;
					r_key = fk_s2; r_parent = fp_s2; r_kind = fn_s2; r_data = fd_s2;
				end else if (full) begin
					r_status = STAT_FULL;
				end else begin
					r_status = STAT_OK;
					r_key = key_q; r_parent = parent_q; r_kind = kind_q; r_data = data_q;
				end
			end
			CMD_UPDATE: begin
				if (hit_s2) begin
					r_status = STAT_OK;
					r_key = fk_s2; r_parent = parent_q; r_kind = kind_q; r_data = data_q;
				end
			end
			CMD_DELETE, CMD_LOOKUP: begin
				if (hit_s2) begin
					r_status = STAT_OK;
					r_key = fk_s2; r_parent = fp_s2; r_kind = fn_s2; r_data = fd_s2;
				end
			end
			CMD_ANCESTOR: begin
				if (walk_match) begin
					r_status = STAT_OK;
					r_key = fk_s2; r_parent = fp_s2; r_kind = fn_s2; r_data = fd_s2;
				end else if (hit_s2 && walk_end) begin
					r_status = STAT_WALK_LIMIT;
				end
			end
			default: ;
		endcase
	end

	// capture the item, advance the walk, hold the result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q    <= cmd;
			key_q    <= key;
			parent_q <= parent_key;
			kind_q   <= product_kind;
			data_q   <= record_data;
			srch_q   <= (cmd == CMD_ANCESTOR) ? parent_key : key;
			steps_q  <= '0;
		end
		if (state_q == S_DECIDE) begin
			status_q  <= r_status;
			fkey_q    <= r_key;
			fparent_q <= r_parent;
			fkind_q   <= r_kind;
			fdata_q   <= r_data;
			if (walk_on) begin
				srch_q  <= fp_s2;
				steps_q <= steps_q + SW'(1);
			end
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = (state_q == S_OUT);
	assign status       = status_q;
	assign found_key    = fkey_q;
	assign found_parent = fparent_q;
	assign found_kind   = fkind_q;
	assign found_data   = fdata_q;
	assign entry_count  = CNT_W'(count_q);

	`SKRT_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(D), "record count beyond depth")
	`SKRT_IMPLY(a_full_status, clk, arst_n, out_valid && status_q == STAT_FULL, full, "early full")
	`SKRT_IMPLY(a_act_hit, clk, arst_n, state_q == S_ACT && cmd_q != CMD_INSERT, hit_s2, "no hit")
endmodule

/* rtl/core/skrt_cell.sv */
module skrt_cell
	import skrt_pkg::*;
#(
	parameter int KB = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [KB-1:0]     in_key,
	input  logic [KB-1:0]     in_parent,
	input  logic [KIND_W-1:0] in_kind,
	input  logic [DATA_W-1:0] in_data,
	input  logic              prev_lt,
	input  logic              prev_valid,
	input  logic [KB-1:0]     prev_key,
	input  logic [KB-1:0]     prev_parent,
	input  logic [KIND_W-1:0] prev_kind,
	input  logic [DATA_W-1:0] prev_data,
	input  logic              next_valid,
	input  logic [KB-1:0]     next_key,
	input  logic [KB-1:0]     next_parent,
	input  logic [KIND_W-1:0] next_kind,
	input  logic [DATA_W-1:0] next_data,
	output logic [KB-1:0]     key_q,
	output logic [KB-1:0]     parent_q,
	output logic [KIND_W-1:0] kind_q,
	output logic [DATA_W-1:0] data_q,
	output cell_stat_t        stat
);
	logic valid_q, lt_q, hit_q;

	assign stat = '{valid: valid_q, lt: lt_q, hit: hit_q};

	// compare flags and occupancy; shift occupancy with the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (ctl.op)
				OP_CMP: begin
					lt_q  <= valid_q && (key_q < in_key);
					hit_q <= valid_q && (key_q == in_key);
				end
				OP_INSERT: begin
					if (!lt_q) valid_q <= prev_lt ? 1'b1 : prev_valid;
				end
				OP_DELETE: begin
					if (!lt_q) valid_q <= next_valid;
				end
				default: ;
			endcase
		end
	end

	// payload: load at insert point, shift up behind it, down on delete, update on hit
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (!lt_q) begin
					if (prev_lt) begin
						key_q    <= in_key;
						parent_q <= in_parent;
						kind_q   <= in_kind;
						data_q   <= in_data;
					end else begin
						key_q    <= prev_key;
						parent_q <= prev_parent;
						kind_q   <= prev_kind;
						data_q   <= prev_data;
					end
				end
			end
			OP_DELETE: begin
				if (!lt_q) begin
					key_q    <= next_key;
					parent_q <= next_parent;
					kind_q   <= next_kind;
					data_q   <= next_data;
				end
			end
			OP_UPDATE: begin
				if (hit_q) begin
					parent_q <= in_parent;
					kind_q   <= in_kind;
					data_q   <= in_data;
				end
			end
			default: ;
		endcase
	end
endmodule
